[sv/fpla_pkg.sv]
// Shared types and constants of the free page list allocator.
// No dependencies; every other file uses these names with fpla_pkg:: scoping.
package fpla_pkg;

  localparam int MaxPages  = 4096;
  localparam int PageW     = $clog2(MaxPages);
  localparam int CountW    = PageW + 1;
  localparam int CfgW      = 11;
  localparam int OpW       = 2;
  localparam int StatusW   = 2;
  localparam int ApbAddrW  = 3;
  localparam int ApbDataW  = 32;
  localparam int GrowLimit = MaxPages / 2;

  localparam logic [CfgW-1:0] InitPagesReset = CfgW'(15);

  typedef enum logic [OpW-1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_CAPACITY = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_RD,
    S_POP,
    S_HOLD
  } state_e;

  // Register indexes, one 32-bit word each.
  localparam logic [0:0] RegInitPages = 1'b0;

endpackage

[sv/fpla_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on fpla_pkg for field widths.
interface fpla_req_if;
  logic                         valid;
  logic                         ready;
  logic [fpla_pkg::OpW-1:0]     op;
  logic [fpla_pkg::PageW-1:0]   page_in;

  modport source (output valid, output op, output page_in, input ready);
  modport sink   (input valid, input op, input page_in, output ready);
endinterface

interface fpla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fpla_pkg::PageW-1:0]    page_out;
  logic [fpla_pkg::StatusW-1:0]  status;

  modport source (output valid, output page_out, output status, input ready);
  modport sink   (input valid, input page_out, input status, output ready);
endinterface

[sv/fpla_cfg.sv]
// APB-style register file holding the format page count.
// Depends on fpla_pkg.
module fpla_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpla_pkg::ApbAddrW-1:0]   paddr,
  input  logic [fpla_pkg::ApbDataW-1:0]   pwdata,
  output logic [fpla_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  output logic [fpla_pkg::CfgW-1:0]       init_pages_o
);

  logic [fpla_pkg::CfgW-1:0] init_pages_q, init_pages_d;
  logic                      sel_init;

  // Word index sits above the byte offset.
  assign sel_init = (paddr[fpla_pkg::ApbAddrW-1] == fpla_pkg::RegInitPages);
  assign pready   = 1'b1;

  always_comb begin
    init_pages_d = init_pages_q;
    if (psel && penable && pwrite && sel_init) begin
      init_pages_d = pwdata[fpla_pkg::CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_pages_q <= fpla_pkg::InitPagesReset;
    end else begin
      init_pages_q <= init_pages_d;
    end
  end

  assign prdata = sel_init ? {{(fpla_pkg::ApbDataW - fpla_pkg::CfgW){1'b0}}, init_pages_q}
                           : '0;
  assign init_pages_o = init_pages_q;

endmodule

[sv/fpla_ctrl.sv]
// Sequencer, link memory and shared walk incrementer of the allocator.
// Depends on fpla_pkg and the channel interfaces in fpla_if.sv.
module fpla_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fpla_pkg::CfgW-1:0]  init_pages_i,
  fpla_req_if.sink                   req,
  fpla_rsp_if.source                 rsp
);

  fpla_pkg::state_e  state_q, state_d;
  fpla_pkg::op_e     op_q, op_d;
  fpla_pkg::status_e res_status_q, res_status_d;
  fpla_pkg::status_e fin_status;
  fpla_pkg::status_e out_status_q;

  logic [fpla_pkg::PageW-1:0]  head_q, head_d;
  logic [fpla_pkg::CountW-1:0] count_q, count_d;
  logic [fpla_pkg::PageW-1:0]  cnt_q, cnt_d;
  logic [fpla_pkg::PageW-1:0]  last_q, last_d;
  logic [fpla_pkg::PageW-1:0]  res_page_q, res_page_d;
  logic [fpla_pkg::PageW-1:0]  fin_page;
  logic [fpla_pkg::PageW-1:0]  out_page_q;
  logic                        out_valid_q;
  logic                        fin_vld, out_free;

  logic [fpla_pkg::PageW-1:0]  cnt_inc;
  logic                        at_last;
  logic [fpla_pkg::CountW-1:0] grow_last;

  logic [fpla_pkg::PageW-1:0]  mem [fpla_pkg::MaxPages];
  logic                        mem_we;
  logic [fpla_pkg::PageW-1:0]  mem_waddr, mem_wdata, rdata_q;

  // Shared walk unit: one incrementer and one compare.
  assign cnt_inc   = cnt_q + 1'b1;
  assign at_last   = (cnt_q == last_q);
  assign grow_last = {count_q[fpla_pkg::CountW-2:0], 1'b0} - 1'b1;

  assign out_free  = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == fpla_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    head_d       = head_q;
    count_d      = count_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    res_page_d   = res_page_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = '0;
    fin_vld      = 1'b0;
    fin_page     = '0;
    fin_status   = fpla_pkg::ST_OK;

    unique case (state_q)
      fpla_pkg::S_IDLE: begin
        if (req.valid) begin
          op_d = fpla_pkg::op_e'(req.op);
          unique case (req.op)
            fpla_pkg::OP_FORMAT: begin
              if (init_pages_i == '0) begin
                count_d = fpla_pkg::CountW'(1);
                head_d  = '0;
                fin_vld = 1'b1;
              end else begin
                count_d = fpla_pkg::CountW'(init_pages_i) + 1'b1;
                head_d  = fpla_pkg::PageW'(1);
                cnt_d   = fpla_pkg::PageW'(1);
                last_d  = fpla_pkg::PageW'(init_pages_i);
                state_d = fpla_pkg::S_WALK;
              end
            end
            fpla_pkg::OP_ALLOC: begin
              if (head_q != '0) begin
                state_d = fpla_pkg::S_POP;
              end else if (count_q == '0 ||
                           count_q > fpla_pkg::CountW'(fpla_pkg::GrowLimit)) begin
                fin_vld    = 1'b1;
                fin_status = fpla_pkg::ST_CAPACITY;
              end else begin
                // Double the store: link the new upper half in order.
                cnt_d   = count_q[fpla_pkg::PageW-1:0];
                last_d  = grow_last[fpla_pkg::PageW-1:0];
                head_d  = count_q[fpla_pkg::PageW-1:0];
                count_d = {count_q[fpla_pkg::CountW-2:0], 1'b0};
                state_d = fpla_pkg::S_WALK;
              end
            end
            fpla_pkg::OP_FREE: begin
              fin_vld = 1'b1;
              if (req.page_in == '0 || {1'b0, req.page_in} >= count_q) begin
                fin_status = fpla_pkg::ST_BAD_FREE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = req.page_in;
                mem_wdata = head_q;
                head_d    = req.page_in;
              end
            end
            default: begin
              fin_vld = 1'b1;
            end
          endcase
        end
      end
      fpla_pkg::S_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = at_last ? '0 : cnt_inc;
        if (at_last) begin
          if (op_q == fpla_pkg::OP_ALLOC) begin
            state_d = fpla_pkg::S_RD;
          end else begin
            fin_vld = 1'b1;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      fpla_pkg::S_RD: begin
        // Let the last link write land before the head link is read.
        state_d = fpla_pkg::S_POP;
      end
      fpla_pkg::S_POP: begin
        fin_vld  = 1'b1;
        fin_page = head_q;
        head_d   = rdata_q;
      end
      fpla_pkg::S_HOLD: begin
        fin_vld    = 1'b1;
        fin_page   = res_page_q;
        fin_status = res_status_q;
      end
      default: begin
        state_d = fpla_pkg::S_IDLE;
      end
    endcase

    if (fin_vld) begin
      if (out_free) begin
        state_d = fpla_pkg::S_IDLE;
      end else begin
        res_page_d   = fin_page;
        res_status_d = fin_status;
        state_d      = fpla_pkg::S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpla_pkg::S_IDLE;
      op_q        <= fpla_pkg::OP_FORMAT;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (fin_vld && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    last_q       <= last_d;
    res_page_q   <= res_page_d;
    res_status_q <= res_status_d;
    if (fin_vld && out_free) begin
      out_page_q   <= fin_page;
      out_status_q <= fin_status;
    end
  end

  // Link memory: one write port, one registered read of the list head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[head_q];
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.page_out = out_page_q;
  assign rsp.status   = out_status_q;

endmodule

[sv/free_page_list_allocator_core.sv]
// Top level of the free page list allocator: APB register file and sequencer.
// Depends on fpla_pkg, fpla_if.sv, fpla_cfg and fpla_ctrl.
//
// Usage
//   req_i carries one request word (op, page_in); rsp_o returns one response
//   word (page_out, status) per request, in order. Both use valid/ready.
//   The APB port holds initial_free_pages at byte address 0 (reset 15);
//   write it only while no request is in flight.
// Sequence
//   Free, an unused opcode, a rejected request and a format of zero pages
//   answer in the accept cycle, or wait in the hold stage while rsp_o stalls.
//   Allocate from a non-empty list reads the head link, then pops. Format of
//   n pages writes one link per cycle through the shared walk incrementer.
//   Allocate that doubles a store of c pages walks c links, then reads the
//   head link and pops. req_i is ready only while the sequencer is idle.
// Reset
//   Clears list head and page count; the link memory is not cleared and
//   needs no sweep, since only written links are ever followed.
// Stall
//   The response register holds a finished word while rsp_o stalls and the
//   next request is still taken; a second result then waits in a hold stage.
module free_page_list_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fpla_req_if.sink                        req_i,
  fpla_rsp_if.source                      rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpla_pkg::ApbAddrW-1:0]   paddr,
  input  logic [fpla_pkg::ApbDataW-1:0]   pwdata,
  output logic [fpla_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  logic [fpla_pkg::CfgW-1:0] init_pages;

  // Configuration register.
  fpla_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .init_pages_o (init_pages)
  );

  // Sequencer with link memory and output register.
  fpla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_pages_i (init_pages),
    .req          (req_i),
    .rsp          (rsp_o)
  );

endmodule

[test/free_page_list_allocator_core_tb.sv]
// Self-checking testbench for free_page_list_allocator_core: a shadow free list predicts
// each response word. Depends on fpla_pkg and the channel interfaces in fpla_if.sv.
module free_page_list_allocator_core_tb;

  // op 3 has no member in op_e; the block must answer it with an empty ok word
  localparam logic [fpla_pkg::OpW-1:0] OpUnused = 2'd3;

  localparam int HoldoffStart   = 250;    // request count that starts the long response stall
  localparam int HoldoffCycles  = 400;
  localparam int WatchdogLimit  = 20000;  // covers the worst growth walk of 2048 links, plus the stall
  localparam int TailCycles     = 50;
  localparam int PhaseItems     = 110;
  localparam int RandomPhases   = 6;
  localparam int GrowAllocs     = 260;

  typedef struct packed {
    logic [fpla_pkg::OpW-1:0]   op;
    logic [fpla_pkg::PageW-1:0] page;
    logic                       from_pool;  // pick a page that is currently handed out
    logic                       drain;      // hold until every pending answer has come back
  } request_t;

  typedef struct packed {
    logic [fpla_pkg::PageW-1:0]   page;
    logic [fpla_pkg::StatusW-1:0] status;
  } answer_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [fpla_pkg::ApbAddrW-1:0] paddr;
  logic [fpla_pkg::ApbDataW-1:0] pwdata;
  logic [fpla_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  fpla_req_if req_if ();
  fpla_rsp_if rsp_if ();

  free_page_list_allocator_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow allocator: links, list head, page count and the latched register value.
  logic [fpla_pkg::PageW-1:0]  link_mem [fpla_pkg::MaxPages];
  logic [fpla_pkg::PageW-1:0]  free_head;
  logic [fpla_pkg::CountW-1:0] store_pages;
  logic [fpla_pkg::CfgW-1:0]   init_pages_cfg;
  // Pages handed out since the last format; frees of these keep the list well formed.
  logic [fpla_pkg::PageW-1:0]  held_pages [$];

  request_t request_plan [$];
  answer_t  pending_answers [$];

  int req_accepts  = 0;
  int mismatches   = 0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int stuck_cycles = 0;

  // Link pages first..first+count-1 ascending; the last one ends the list.
  function automatic void link_ascending(input int first, input int count);
    for (int i = 0; i < count; i++)
      link_mem[first + i] = (i + 1 == count) ? '0 : fpla_pkg::PageW'(first + i + 1);
  endfunction

  // Advance the shadow free list by one request and return the word it must produce.
  function automatic answer_t apply_request(input logic [fpla_pkg::OpW-1:0] op,
                                            input logic [fpla_pkg::PageW-1:0] pg);
    answer_t ans;
    int      n;
    ans.page   = '0;
    ans.status = fpla_pkg::ST_OK;
    case (op)
      fpla_pkg::OP_FORMAT: begin
        n = int'(init_pages_cfg);
        if (n > fpla_pkg::MaxPages - 1) n = fpla_pkg::MaxPages - 1;
        store_pages = fpla_pkg::CountW'(n + 1);
        link_ascending(1, n);
        free_head = (n != 0) ? fpla_pkg::PageW'(1) : '0;
        held_pages.delete();
      end
      fpla_pkg::OP_ALLOC: begin
        // an empty list must double the store; refuse before any format or past capacity
        if (free_head == '0 && (store_pages == '0 || store_pages > fpla_pkg::GrowLimit)) begin
          ans.status = fpla_pkg::ST_CAPACITY;
        end else begin
          if (free_head == '0) begin
            link_ascending(int'(store_pages), int'(store_pages));
            free_head   = fpla_pkg::PageW'(store_pages);
            store_pages = store_pages << 1;
          end
          ans.page  = free_head;
          free_head = link_mem[free_head];
          held_pages.push_back(ans.page);
        end
      end
      fpla_pkg::OP_FREE: begin
        // the header page and pages past the count are rejected; double frees are not
        if (pg == '0 || fpla_pkg::CountW'(pg) >= store_pages) begin
          ans.status = fpla_pkg::ST_BAD_FREE;
        end else begin
          link_mem[pg] = free_head;
          free_head    = pg;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    mismatches++;
  endtask

  task automatic queue_request(input logic [fpla_pkg::OpW-1:0] op,
                               input logic [fpla_pkg::PageW-1:0] page,
                               input logic from_pool, input logic drain);
    request_plan.push_back('{op: op, page: page, from_pool: from_pool, drain: drain});
  endtask

  // Hold until the plan is sent, the channel is empty and every answer has come back.
  task automatic wait_idle();
    while (request_plan.size() != 0 || req_if.valid || pending_answers.size() != 0)
      @(posedge clk_i);
  endtask

  // Write the single register through a setup and an access phase.
  task automatic write_init_pages(input logic [fpla_pkg::CfgW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fpla_pkg::ApbAddrW'(4 * fpla_pkg::RegInitPages);
    pwdata  <= fpla_pkg::ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    init_pages_cfg <= value;
  endtask

  // Request driver: predict on acceptance, then offer the next planned word or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t nxt;
    logic     slot_free;
    int       pick;
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.op      <= fpla_pkg::OP_FORMAT;
      req_if.page_in <= '0;
      tx_gap         <= 0;
    end else begin
      slot_free = !req_if.valid;
      if (req_if.valid && req_if.ready) begin
        pending_answers.push_back(apply_request(req_if.op, req_if.page_in));
        req_accepts <= req_accepts + 1;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (tx_gap != 0) begin
          tx_gap       <= tx_gap - 1;
          req_if.valid <= 1'b0;
        end else if (request_plan.size() != 0 && $urandom_range(99) < gap_pct) begin
          // idle burst that starts with this slot; tx_gap holds the rest of it
          tx_gap       <= $urandom_range(9);
          req_if.valid <= 1'b0;
        end else if (request_plan.size() != 0 &&
                     !(request_plan[0].drain && pending_answers.size() != 0)) begin
          nxt = request_plan.pop_front();
          if (nxt.from_pool) begin
            if (held_pages.size() != 0) begin
              pick     = $urandom_range(held_pages.size() - 1);
              nxt.page = held_pages[pick];
              held_pages.delete(pick);
            end else begin
              nxt.page = fpla_pkg::PageW'($urandom_range(1, 15));
            end
          end
          req_if.valid   <= 1'b1;
          req_if.op      <= nxt.op;
          req_if.page_in <= nxt.page;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Start one long response stall once traffic is flowing; the sender keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin : long_holdoff
    if (!rst_ni) begin
      holdoff_left <= 0;
    end else if (!holdoff_done && req_accepts >= HoldoffStart) begin
      holdoff_left <= HoldoffCycles;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Response monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_answers
    answer_t want;
    logic    rdy;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("word with nothing pending, page_out", 0, rsp_if.page_out);
        end else begin
          want = pending_answers.pop_front();
          if (rsp_if.page_out !== want.page)
            report_mismatch("page_out", want.page, rsp_if.page_out);
          if (rsp_if.status !== want.status)
            report_mismatch("status", want.status, rsp_if.status);
        end
      end
      if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        rdy = 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        rx_gap <= $urandom_range(9);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      if (holdoff_left != 0) rdy = 1'b0;
      rsp_if.ready <= rdy;
    end
  end

  // Abort when neither channel moves a word for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [fpla_pkg::CfgW-1:0]  cfg_pick;
    logic [fpla_pkg::PageW-1:0] rnd_page;
    int unsigned                roll;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    free_head      = '0;
    store_pages    = '0;
    init_pages_cfg = fpla_pkg::InitPagesReset;
    foreach (link_mem[i]) link_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, register at its reset value: touch the store before any format,
    // then the bounds of free and the ignored page field.
    gap_pct   <= 10;
    stall_pct <= 10;
    queue_request(fpla_pkg::OP_ALLOC, 12'hFFF, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd5, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd0, 1'b0, 1'b0);
    queue_request(OpUnused, 12'hABC, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FORMAT, 12'hFFF, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'h555, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'hAAA, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd0, 1'b1, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd16, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd4095, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd15, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b1);
    queue_request(OpUnused, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FORMAT, 12'd0, 1'b0, 1'b0);
    wait_idle();

    // Format of zero pages leaves an empty list; the next allocates grow 1 -> 2 -> 4.
    write_init_pages(fpla_pkg::CfgW'(0));
    queue_request(fpla_pkg::OP_FORMAT, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd1, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd4, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);

    // Random phases, each after a register write: mostly allocate and free of held
    // pages, with stray frees, reformats and the unused opcode mixed in.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_idle();
      case (ph)
        0:       cfg_pick = fpla_pkg::CfgW'(1);
        1:       cfg_pick = fpla_pkg::CfgW'(2047);
        2:       cfg_pick = fpla_pkg::CfgW'(6);
        3:       cfg_pick = fpla_pkg::CfgW'(0);
        default: cfg_pick = fpla_pkg::CfgW'($urandom_range(1, 64));
      endcase
      write_init_pages(cfg_pick);
      case ($urandom_range(3))
        0:       gap_pct <= 0;
        1:       gap_pct <= 5;
        2:       gap_pct <= 20;
        default: gap_pct <= 40;
      endcase
      case ($urandom_range(3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 5;
        2:       stall_pct <= 20;
        default: stall_pct <= 40;
      endcase
      queue_request(fpla_pkg::OP_FORMAT,
                    fpla_pkg::PageW'($urandom_range(fpla_pkg::MaxPages - 1)), 1'b0, 1'b0);
      repeat (PhaseItems) begin
        roll     = $urandom_range(99);
        rnd_page = fpla_pkg::PageW'($urandom_range(fpla_pkg::MaxPages - 1));
        if (roll < 48)
          queue_request(fpla_pkg::OP_ALLOC, rnd_page, 1'b0, $urandom_range(99) < 2);
        else if (roll < 78)
          queue_request(fpla_pkg::OP_FREE, rnd_page, 1'b1, $urandom_range(99) < 2);
        else if (roll < 84)
          queue_request(fpla_pkg::OP_FREE, rnd_page, 1'b0, 1'b0);
        else if (roll < 89)
          queue_request(fpla_pkg::OP_FREE, fpla_pkg::PageW'($urandom_range(64)), 1'b0, 1'b0);
        else if (roll < 94)
          queue_request(fpla_pkg::OP_FORMAT, rnd_page, 1'b0, 1'b0);
        else
          queue_request(OpUnused, rnd_page, 1'b0, 1'b0);
      end
    end

    // Final part, no idling: exhaust a store of 256 pages, grow it to 512 once, then
    // probe the free bounds at the new count and allocate again.
    wait_idle();
    write_init_pages(fpla_pkg::CfgW'(255));
    gap_pct   <= 0;
    stall_pct <= 0;
    queue_request(fpla_pkg::OP_FORMAT, 12'd0, 1'b0, 1'b0);
    repeat (GrowAllocs)
      queue_request(fpla_pkg::OP_ALLOC,
                    fpla_pkg::PageW'($urandom_range(fpla_pkg::MaxPages - 1)), 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd4095, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd512, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_FREE, 12'd100, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    queue_request(fpla_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0);
    wait_idle();

    // let any stray word show up before judging
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
sv/fpla_pkg.sv
sv/fpla_if.sv
sv/fpla_cfg.sv
sv/fpla_ctrl.sv
sv/free_page_list_allocator_core.sv
test/free_page_list_allocator_core_tb.sv
